// ===== rtl/stf_pkg.sv =====
// Shared types and constants of the semaphore table with FIFO waiter queues.
// Used by semaphore_table_fifo_waiters; depends on nothing.
`default_nettype none

package stf_pkg;

  localparam int DEF_NUM_SEMS  = 16;
  localparam int DEF_NUM_PROCS = 16;

  localparam int ID_W   = 4;
  localparam int IVAL_W = 15;
  localparam int CNT_W  = 16;

  localparam logic signed [CNT_W-1:0] COUNT_MAX = 16'sd32767;

  typedef enum logic [1:0] {
    FUNC_INIT   = 2'd0,
    FUNC_WAIT   = 2'd1,
    FUNC_SIGNAL = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [ID_W-1:0]   proc_id;
    logic [ID_W-1:0]   sem_id;
    logic [IVAL_W-1:0] init_value;
  } stf_req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] new_sem;
    logic            caller_blocks;
    logic            wake_valid;
    logic [ID_W-1:0] wake_proc;
  } stf_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/stf_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Depends on nothing.
`default_nettype none

module stf_ram #(
  parameter int AW    = 4,
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is held until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/semaphore_table_fifo_waiters.sv =====
// Top level of the counting semaphore table with per-entry FIFO waiter queues.
// Depends on stf_pkg and stf_ram.
`default_nettype none

// The block keeps NUM_SEMS counting semaphores, each with a FIFO of up to
// NUM_PROCS waiting processes, and answers every request with exactly one
// response. An init request takes the lowest free entry (entries are handed
// out in order and never freed, so this is simply an allocation counter),
// loads its count and empties its queue. A wait decrements the count; when
// no count is left, the caller is appended to the entry's queue and told to
// block, and a full queue is reported instead. A signal increments the count
// (saturating at 32767) or, when processes are queued, removes the oldest
// one and reports it to be woken. Requests naming an index that was never
// allocated are rejected with an unknown-semaphore status. The state lives
// in two synchronous RAMs: a semaphore table holding count, queue head and
// queue tail per entry, and a waiter RAM holding the queued process IDs.
// A request is accepted in the idle state, which reads the semaphore table;
// the execute state then modifies and writes the entry back and, but for a
// wake, loads the response register. The next request is accepted once the
// block is idle again. A signal that wakes a waiter passes through a wake
// state for the waiter RAM read, which loads its response. No clearing pass
// is needed after reset. A response waiting at the output does not keep the
// next request from being accepted and read; the block only holds its
// write-back, or on a wake its response, until the output register is free.

module semaphore_table_fifo_waiters #(
  parameter int NUM_SEMS  = stf_pkg::DEF_NUM_SEMS,
  parameter int NUM_PROCS = stf_pkg::DEF_NUM_PROCS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire stf_pkg::stf_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output stf_pkg::stf_rsp_t      out_data
);

  import stf_pkg::*;

  localparam int SW      = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int CW      = $clog2(NUM_SEMS + 1);
  localparam int PW      = $clog2(NUM_PROCS);
  localparam int IDW     = (SW > ID_W) ? SW : ID_W;
  localparam int ENT_W   = CNT_W + 2 * PW;
  localparam int RING_AW = SW + PW;
  localparam int RING_D  = NUM_SEMS * (2 ** PW);

  localparam logic signed [CNT_W-1:0] CNT_FLOOR = CNT_W'(-NUM_PROCS);
  localparam logic [PW-1:0]           PTR_LAST  = PW'(NUM_PROCS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAKE
  } state_t;

  state_t            state_r;
  stf_req_t          req_r;
  logic [CW-1:0]     alloc_cnt_r;
  logic              out_valid_r;
  stf_rsp_t          out_data_r;

  // Semaphore table ports.
  logic              sem_we;
  logic [SW-1:0]     sem_waddr;
  logic [ENT_W-1:0]  sem_wdata;
  logic              sem_re;
  logic [SW-1:0]     sem_raddr;
  logic [ENT_W-1:0]  sem_rdata;

  // Waiter RAM ports.
  logic              ring_we;
  logic [RING_AW-1:0] ring_waddr;
  logic              ring_re;
  logic [RING_AW-1:0] ring_raddr;
  logic [ID_W-1:0]   ring_rdata;

  logic [IDW-1:0]    in_sid_ext;
  logic [IDW-1:0]    req_sid_ext;
  logic [SW-1:0]     req_sid;
  logic              sid_known;
  logic              slot_free;
  logic              commit;

  logic signed [CNT_W-1:0] cnt;
  logic [PW-1:0]     head;
  logic [PW-1:0]     tail;
  logic [PW-1:0]     head_nxt;
  logic [PW-1:0]     tail_nxt;

  logic              upd_we;
  logic [ENT_W-1:0]  upd_wdata;
  logic              upd_ring_we;
  logic              wake_path;
  logic              alloc_inc;
  stf_rsp_t          rsp_exec;
  stf_rsp_t          rsp_wake;
  logic              rsp_load;

  stf_ram #(
    .AW    (SW),
    .DEPTH (NUM_SEMS),
    .WIDTH (ENT_W)
  ) u_sem_table (
    .clk   (clk),
    .we    (sem_we),
    .waddr (sem_waddr),
    .wdata (sem_wdata),
    .re    (sem_re),
    .raddr (sem_raddr),
    .rdata (sem_rdata)
  );

  stf_ram #(
    .AW    (RING_AW),
    .DEPTH (RING_D),
    .WIDTH (ID_W)
  ) u_waiters (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (req_r.proc_id),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;

  // The table is read at the accept edge, so the entry is ready in S_EXEC.
  assign in_sid_ext = IDW'(in_data.sem_id);
  assign sem_re     = in_valid && in_ready;
  assign sem_raddr  = in_sid_ext[SW-1:0];

  assign req_sid_ext = IDW'(req_r.sem_id);
  assign req_sid     = req_sid_ext[SW-1:0];
  // Entries are allocated in order, so an index is live exactly when it is
  // below the allocation count, which also covers indexes past the table.
  assign sid_known   = (32'(req_r.sem_id) < 32'(alloc_cnt_r));

  assign cnt  = sem_rdata[ENT_W-1 -: CNT_W];
  assign head = sem_rdata[2*PW-1 -: PW];
  assign tail = sem_rdata[PW-1:0];

  assign head_nxt = (head == PTR_LAST) ? '0 : head + PW'(1);
  assign tail_nxt = (tail == PTR_LAST) ? '0 : tail + PW'(1);

  always_comb begin
    upd_we      = 1'b0;
    upd_wdata   = sem_rdata;
    upd_ring_we = 1'b0;
    wake_path   = 1'b0;
    alloc_inc   = 1'b0;
    sem_waddr   = req_sid;
    rsp_exec    = '0;
    unique case (req_r.func)
      FUNC_INIT: begin
        if (alloc_cnt_r == CW'(NUM_SEMS)) begin
          rsp_exec.status = ST_NO_FREE;
        end else begin
          upd_we           = 1'b1;
          sem_waddr        = alloc_cnt_r[SW-1:0];
          upd_wdata        = {CNT_W'(req_r.init_value), {(2*PW){1'b0}}};
          alloc_inc        = 1'b1;
          rsp_exec.new_sem = ID_W'(alloc_cnt_r);
        end
      end
      FUNC_WAIT: begin
        if (!sid_known) begin
          rsp_exec.status = ST_UNKNOWN;
        end else if (cnt > 0) begin
          upd_we    = 1'b1;
          upd_wdata = {cnt - CNT_W'(1), head, tail};
        end else if (cnt <= CNT_FLOOR) begin
          rsp_exec.status = ST_FULL;
        end else begin
          upd_we                 = 1'b1;
          upd_ring_we            = 1'b1;
          upd_wdata              = {cnt - CNT_W'(1), head, tail_nxt};
          rsp_exec.caller_blocks = 1'b1;
        end
      end
      FUNC_SIGNAL: begin
        if (!sid_known) begin
          rsp_exec.status = ST_UNKNOWN;
        end else if (cnt < 0) begin
          // Oldest waiter is read from the waiter RAM in the next cycle.
          upd_we    = 1'b1;
          wake_path = 1'b1;
          upd_wdata = {cnt + CNT_W'(1), head_nxt, tail};
        end else if (cnt < COUNT_MAX) begin
          upd_we    = 1'b1;
          upd_wdata = {cnt + CNT_W'(1), head, tail};
        end
      end
      default: begin
      end
    endcase
  end

  // The wake response carries only the released process.
  always_comb begin
    rsp_wake            = '0;
    rsp_wake.wake_valid = 1'b1;
    rsp_wake.wake_proc  = ring_rdata;
  end

  // Write-back happens only when the response can be stored, except on the
  // wake path, which produces its response from the wake state.
  assign commit     = (state_r == S_EXEC) && (wake_path || slot_free);
  assign sem_we     = commit && upd_we;
  assign sem_wdata  = upd_wdata;
  assign ring_we    = commit && upd_ring_we;
  assign ring_waddr = {req_sid, tail};
  assign ring_re    = commit && wake_path;
  assign ring_raddr = {req_sid, head};

  // The response register is loaded at the end of execute, or of the wake
  // cycle when a waiter is released.
  assign rsp_load = (commit && !wake_path) || ((state_r == S_WAKE) && slot_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alloc_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rsp_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= (state_r == S_WAKE) ? rsp_wake : rsp_exec;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            if (alloc_inc) begin
              alloc_cnt_r <= alloc_cnt_r + CW'(1);
            end
            if (wake_path) begin
              state_r <= S_WAKE;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_WAKE: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The allocation counter never passes the table size.
  a_alloc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(alloc_cnt_r) <= 32'(NUM_SEMS))
    else $error("allocation count beyond table size");

  // A response appears only after an execute or wake cycle.
  a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_WAKE))
    else $error("response produced outside execute or wake");

  // The wake cycle always follows a committed signal with waiters.
  a_wake_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAKE && $past(state_r) != S_WAKE) |->
      ($past(state_r) == S_EXEC && $past(ring_re)))
    else $error("wake cycle without waiter read");

  // A request never both queues and dequeues a waiter.
  a_ring_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_we && ring_re))
    else $error("waiter RAM read and write in one cycle");

  // A new request is read only when the previous one has left the table.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sem_re |-> !sem_we)
    else $error("table read overlaps a write-back");

endmodule

`default_nettype wire
